@@ sv/xsfb_pkg.sv @@
package xsfb_pkg;

  // Geometry defaults. A row word is always 64 bits wide, with column zero in bit 63.
  localparam int unsigned SCREEN_WIDTH_DEF  = 64;
  localparam int unsigned SCREEN_HEIGHT_DEF = 32;
  localparam int unsigned ROW_W             = 64;
  localparam int unsigned COUNT_W           = 32;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2
  } op_t;

endpackage

@@ sv/xsfb_ram.sv @@
module xsfb_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/xor_sprite_framebuffer_unit.sv @@
// Monochrome framebuffer with XOR sprite drawing, in the style of a CHIP-8 display.
// Each request on the input channel (in_valid/in_stall) carries an op: clear the
// screen, XOR one sprite line into a row, or read one row word. Every request gives
// exactly one response on the output channel (out_valid/out_stall). That response
// carries the collision flag, a row word, the frame counter and the sprite-done flag.
// The rows live in a synchronous RAM with one read port. A request is accepted in
// IDLE, and its row is read at that edge. In the next cycle the row is modified,
// written back and placed in the output register, which raises out_valid. No new
// request is taken until this single read-modify-write pass through the row RAM
// is through. A clear goes through the same pass, because it drops a valid bit
// per row rather than sweeping the RAM. A row whose valid bit is low reads as
// zero.
// The output register parts the two channels, so a new request is taken while a
// response still waits. If the receiver is still stalling when the next response is
// ready, that request holds in its modify cycle and writes nothing until the output
// register frees up.
// Reset (rst, synchronous, active high) clears the valid bits, the collision flag,
// the frame counter and the control state at once; no clearing pass is needed.
module xor_sprite_framebuffer_unit #(
  parameter int unsigned SCREEN_WIDTH  = xsfb_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = xsfb_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    op,
  input  logic [7:0]                    x_pos,
  input  logic [7:0]                    y_pos,
  input  logic [3:0]                    row_offset,
  input  logic [7:0]                    sprite_byte,
  input  logic                          last_row,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          collision,
  output logic [xsfb_pkg::ROW_W-1:0]    row_data,
  output logic [xsfb_pkg::COUNT_W-1:0]  frame_count,
  output logic                          sprite_done
);

  import xsfb_pkg::*;

  localparam int unsigned AW = $clog2(SCREEN_HEIGHT);
  localparam logic [8:0]  HEIGHT9 = 9'(SCREEN_HEIGHT);
  // Columns at or beyond the screen width are never drawn.
  localparam logic [ROW_W-1:0] COL_MASK = ~({ROW_W{1'b1}} >> SCREEN_WIDTH);

  typedef enum logic {
    S_IDLE,
    S_MOD
  } state_t;

  state_t state;

  // Request fields latched at accept.
  op_t          op_q;
  logic [7:0]   x_q;
  logic [3:0]   offset_q;
  logic [7:0]   byte_q;
  logic         last_q;
  logic [AW-1:0] addr_q;
  logic         in_range_q;

  logic [SCREEN_HEIGHT-1:0] row_valid;
  logic                     collision_flag;
  logic [COUNT_W-1:0]       frame_counter;

  logic in_accept;
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  // Target row for a draw: y clamped to the last row, plus the line offset.
  logic [7:0] y_clamped;
  logic [8:0] draw_row;
  logic       draw_in_range;
  logic       read_in_range;
  logic [AW-1:0] rd_addr;

  always_comb begin
    y_clamped     = ({1'b0, y_pos} >= HEIGHT9) ? 8'(SCREEN_HEIGHT - 1) : y_pos;
    draw_row      = {1'b0, y_clamped} + {5'd0, row_offset};
    draw_in_range = (draw_row < HEIGHT9);
    read_in_range = ({1'b0, y_pos} < HEIGHT9);
    rd_addr       = (op_t'(op) == OP_DRAW) ? draw_row[AW-1:0] : y_pos[AW-1:0];
  end

  logic [ROW_W-1:0] rd_data;
  logic [ROW_W-1:0] cur_word;
  logic [ROW_W-1:0] draw_mask;
  logic [ROW_W-1:0] new_word;
  logic             hit;
  logic             out_free;
  logic             wr_en;

  always_comb begin
    cur_word  = row_valid[addr_q] ? rd_data : '0;
    draw_mask = ({byte_q, {(ROW_W-8){1'b0}}} >> x_q) & COL_MASK;
    new_word  = cur_word ^ draw_mask;
    hit       = in_range_q && ((cur_word & draw_mask) != '0);
    out_free  = !out_valid || !out_stall;
    wr_en     = (state == S_MOD) && out_free && (op_q == OP_DRAW) && in_range_q;
  end

  xsfb_ram #(
    .WIDTH(ROW_W),
    .DEPTH(SCREEN_HEIGHT)
  ) u_rows (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(addr_q),
    .wr_data(new_word),
    .rd_en  (in_accept),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      collision_flag <= 1'b0;
      frame_counter  <= '0;
      row_valid      <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            op_q       <= op_t'(op);
            x_q        <= x_pos;
            offset_q   <= row_offset;
            byte_q     <= sprite_byte;
            last_q     <= last_row;
            addr_q     <= rd_addr;
            in_range_q <= (op_t'(op) == OP_DRAW) ? draw_in_range : read_in_range;
            state      <= S_MOD;
          end
        end
        S_MOD: begin
          if (out_free) begin
            // The response register is loaded here, in the same cycle as the write-back.
            out_valid   <= 1'b1;
            row_data    <= '0;
            sprite_done <= 1'b0;
            collision   <= collision_flag;
            frame_count <= frame_counter;
            unique case (op_q)
              OP_CLEAR: begin
                row_valid     <= '0;
                frame_counter <= frame_counter + 1'b1;
                frame_count   <= frame_counter + 1'b1;
              end
              OP_DRAW: begin
                // Line zero starts a new sprite and drops the old collision.
                collision_flag <= ((offset_q != '0) && collision_flag) || hit;
                collision      <= ((offset_q != '0) && collision_flag) || hit;
                if (in_range_q) begin
                  row_valid[addr_q] <= 1'b1;
                  row_data          <= new_word;
                end
                if (last_q) begin
                  sprite_done   <= 1'b1;
                  frame_counter <= frame_counter + 1'b1;
                  frame_count   <= frame_counter + 1'b1;
                end
              end
              OP_READ: begin
                if (in_range_q) begin
                  row_data <= cur_word;
                end
              end
              default: begin
              end
            endcase
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_to_mod: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == S_MOD))
    else $error("accepted request did not move to the modify cycle");

  a_resp_from_mod: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_MOD))
    else $error("response loaded outside the modify cycle");

  a_no_write_when_blocked: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOD && out_valid && out_stall) |-> !wr_en)
    else $error("row written while the response register is full");

  a_counter_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(frame_counter)) |->
      (frame_counter == COUNT_W'($past(frame_counter) + 1'b1)))
    else $error("frame counter moved by more than one");

endmodule
